// File: hw/rtl/percent_escape_encoder_macros.svh
// Assertion macros shared by the percent escape encoder checkers.
`ifndef PERCENT_ESCAPE_ENCODER_MACROS_SVH
`define PERCENT_ESCAPE_ENCODER_MACROS_SVH

// Concurrent assertion sampled on the rising clock and held off while reset is low.
`define PEE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is applied.
`define PEE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/pee_pkg.sv
// Shared types, constants and register codes of the percent escape encoder.
package pee_pkg;

    localparam int UNIT_W      = 16;
    localparam int NUM_REGS    = 6;
    localparam int EXTRA_SLOTS = 6;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;
    localparam int REG_IDX_W   = ADDR_W - 2;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [UNIT_W-1:0] CTRL_LIMIT   = 16'h0019;
    localparam logic [UNIT_W-1:0] PERCENT_CHAR = 16'h0025;

    typedef logic [UNIT_W-1:0] unit_t;
    typedef unit_t [NUM_REGS-1:0] extra_arr_t;

    typedef struct packed {
        unit_t unit;
        logic  esc;
    } entry_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_EXTRA_A = 3'd0,
        REG_EXTRA_B = 3'd1,
        REG_EXTRA_C = 3'd2,
        REG_EXTRA_D = 3'd3,
        REG_EXTRA_E = 3'd4,
        REG_EXTRA_F = 3'd5
    } reg_idx_t;

    typedef enum logic {
        BK_HEAD,
        BK_DIGIT
    } back_state_t;

endpackage

// File: hw/rtl/pee_front.sv
// Front end: accepts requests and classifies each code unit as escaped or passed.
module pee_front (
    input  logic               in_valid,
    output logic               in_stall,
    input  pee_pkg::unit_t     code_unit,
    input  pee_pkg::extra_arr_t extra,
    input  logic               q_full,
    output logic               push,
    output pee_pkg::entry_t    push_entry
);
    import pee_pkg::*;

    logic esc;

    always_comb
    begin
        esc = (code_unit <= CTRL_LIMIT) || (code_unit == PERCENT_CHAR);
        for (int i = 0; i < EXTRA_SLOTS; i++)
        begin
            // An empty slot holds zero and never matches.
            if ((extra[i] != '0) && (extra[i] == code_unit))
            begin
                esc = 1'b1;
            end
        end
    end

    assign in_stall        = q_full;
    assign push            = in_valid && !q_full;
    assign push_entry.unit = code_unit;
    assign push_entry.esc  = esc;

endmodule

// File: hw/rtl/pee_queue.sv
// Short queue of classified units between the front end and the emitter.
module pee_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pee_pkg::entry_t push_entry,
    input  logic            pop,
    output logic            full,
    output logic            empty,
    output pee_pkg::entry_t head
);
    import pee_pkg::*;

    entry_t               slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;

    assign full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: hw/rtl/pee_back.sv
// Back end: expands escaped units into a percent sign and four hex digits.
module pee_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            empty,
    input  pee_pkg::entry_t head,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output pee_pkg::unit_t  out_unit,
    output logic            run_last
);
    import pee_pkg::*;

    localparam logic [1:0] LAST_DIGIT = 2'd3;

    back_state_t state_reg;
    back_state_t state_next;
    logic [1:0]  digit_reg;
    logic [1:0]  digit_next;
    unit_t       unit_reg;
    unit_t       unit_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    unit_t       out_unit_reg;
    unit_t       out_unit_next;
    logic        run_last_reg;
    logic        run_last_next;
    logic        load;
    logic [3:0]  nib;
    unit_t       hex_char;

    always_comb
    begin
        case (digit_reg)
            2'd0:    nib = unit_reg[15:12];
            2'd1:    nib = unit_reg[11:8];
            2'd2:    nib = unit_reg[7:4];
            default: nib = unit_reg[3:0];
        endcase
        // Digits map to 0x30..0x39, letters to uppercase 0x41..0x46.
        if (nib < 4'd10)
        begin
            hex_char = 16'h0030 + UNIT_W'(nib);
        end
        else
        begin
            hex_char = 16'h0037 + UNIT_W'(nib);
        end
    end

    // The output register takes a new result whenever it is empty or being drained.
    assign load = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        digit_next     = digit_reg;
        unit_next      = unit_reg;
        out_valid_next = out_valid_reg;
        out_unit_next  = out_unit_reg;
        run_last_next  = run_last_reg;
        pop            = 1'b0;
        unique case (state_reg)
            BK_HEAD:
            begin
                if (load)
                begin
                    out_valid_next = !empty;
                    if (!empty)
                    begin
                        pop = 1'b1;
                        if (head.esc)
                        begin
                            out_unit_next = PERCENT_CHAR;
                            run_last_next = 1'b0;
                            unit_next     = head.unit;
                            digit_next    = '0;
                            state_next    = BK_DIGIT;
                        end
                        else
                        begin
                            out_unit_next = head.unit;
                            run_last_next = 1'b1;
                        end
                    end
                end
            end
            BK_DIGIT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_unit_next  = hex_char;
                    run_last_next  = (digit_reg == LAST_DIGIT);
                    digit_next     = digit_reg + 1'b1;
                    if (digit_reg == LAST_DIGIT)
                    begin
                        state_next = BK_HEAD;
                    end
                end
            end
            default:
            begin
                state_next = BK_HEAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_HEAD;
            digit_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            digit_reg     <= digit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unit_reg     <= unit_next;
        out_unit_reg <= out_unit_next;
        run_last_reg <= run_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_unit  = out_unit_reg;
    assign run_last  = run_last_reg;

endmodule

// File: hw/rtl/percent_escape_encoder.sv
// Top level of the percent escape encoder with its configuration registers.
//
// Input channel: in_valid, in_stall, code_unit carry one 16-bit code unit per request.
// Output channel: out_valid, out_stall, out_unit, run_last carry the results, one unit each.
// A unit that is 0x19 or less, the percent sign, or equal to a nonzero extra character
// becomes five results: a percent sign and four uppercase hex digits, high digit first.
// Any other unit passes through as one result. run_last marks the final result of a unit.
// An accepted unit is written into the queue and then loaded into the output register.
// Plain units flow at one per cycle unless out_stall holds them. An escaped unit holds
// the output register for its five results, made at one per cycle when not stalled; a
// four-entry queue keeps accepting input meanwhile and raises in_stall only when full.
// When the receiver stalls, the output register holds its result and the queue fills.
// The extra characters sit at APB byte addresses 0x00 to 0x14; pready is always high.
// Reset clears the registers to zero, empties the queue and drops out_valid.
module percent_escape_encoder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pee_pkg::ADDR_W-1:0]  paddr,
    input  logic [pee_pkg::DATA_W-1:0]  pwdata,
    output logic [pee_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  pee_pkg::unit_t              code_unit,
    output logic                        out_valid,
    input  logic                        out_stall,
    output pee_pkg::unit_t              out_unit,
    output logic                        run_last
);
    import pee_pkg::*;

    extra_arr_t extra_reg;
    extra_arr_t extra_next;
    reg_idx_t   reg_idx;
    logic       wr_en;
    unit_t      rd_val;
    logic       q_full;
    logic       q_empty;
    logic       push;
    logic       pop;
    entry_t     push_entry;
    entry_t     head;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_comb
    begin
        extra_next = extra_reg;
        rd_val     = '0;
        unique case (reg_idx)
            REG_EXTRA_A, REG_EXTRA_B, REG_EXTRA_C,
            REG_EXTRA_D, REG_EXTRA_E, REG_EXTRA_F:
            begin
                rd_val = extra_reg[reg_idx];
                if (wr_en)
                begin
                    extra_next[reg_idx] = pwdata[UNIT_W-1:0];
                end
            end
            default:
            begin
                // Addresses past the register list read as zero and ignore writes.
                rd_val = '0;
            end
        endcase
    end

    assign prdata = DATA_W'(rd_val);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extra_reg <= '0;
        end
        else
        begin
            extra_reg <= extra_next;
        end
    end

    pee_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .code_unit  (code_unit),
        .extra      (extra_reg),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    pee_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .empty      (q_empty),
        .head       (head)
    );

    pee_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (q_empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_unit   (out_unit),
        .run_last   (run_last)
    );

endmodule

// File: hw/rtl/pee_checker.sv
// Port-level checks on the percent escape encoder, bound to its top level.
`include "percent_escape_encoder_macros.svh"

module pee_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        psel,
    input logic                        pwrite,
    input logic [pee_pkg::DATA_W-1:0]  prdata,
    input logic                        out_valid,
    input logic                        out_stall,
    input pee_pkg::unit_t              out_unit,
    input logic                        run_last
);
    import pee_pkg::*;

    logic              stalled;
    logic [UNIT_W+1:0] out_word;
    logic              mid_result;
    logic              mid_char;
    logic              read_cycle;
    logic              upper_zero;

    assign stalled    = out_valid && out_stall;
    assign out_word   = {out_valid, out_unit, run_last};
    assign mid_result = out_valid && !run_last;
    assign mid_char   = (out_unit == PERCENT_CHAR)
                        || (out_unit >= 16'h0030 && out_unit <= 16'h0039)
                        || (out_unit >= 16'h0041 && out_unit <= 16'h0046);
    assign read_cycle = psel && !pwrite;
    assign upper_zero = (prdata[DATA_W-1:UNIT_W] == '0);

    // A stalled result keeps its valid, its value and its marker.
    `PEE_ASSERT(a_out_hold, clk, rst_n, stalled |=> $stable(out_word), "stalled result changed")

    // A result that does not end its run is the percent sign or an uppercase hex digit.
    `PEE_ASSERT(a_mid_run_char, clk, rst_n, mid_result |-> mid_char, "bad escape character")

    // The output is empty right after reset is released.
    `PEE_ASSERT_ALWAYS(a_reset_quiet, clk, $rose(rst_n) |-> !out_valid, "output busy after reset")

    // Register reads carry only sixteen data bits.
    `PEE_ASSERT(a_prdata_upper, clk, rst_n, read_cycle |-> upper_zero, "read data above bit 15")

endmodule

bind percent_escape_encoder pee_checker u_pee_checker (.*);
